FILE: design/wtk_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the windowed top-K selector.
// No dependencies; used by wtk_cell and windowed_top_k_select.
package wtk_pkg;

  localparam int unsigned TopKDefault = 10;
  localparam int unsigned IpWidth     = 32;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned KeyWidth    = 2 * IpWidth;
  localparam int unsigned WindowWidth = 16;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // store not full: insert after all entries with count <= new count
    logic evict;  // store full, new count beats the lowest: drop lowest, then insert
    logic shift;  // flush: every cell takes its upper neighbor
  } cell_cmd_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic                  valid;
    logic                  le;     // held count <= incoming count
    logic [KeyWidth-1:0]   key;    // src in high half, dst in low half
    logic [CountWidth-1:0] cnt;
  } cell_link_t;

endpackage

FILE: design/wtk_cell.sv
`timescale 1ns / 1ps
// One entry of the sorted chain: key, count and valid flag.
// Depends on wtk_pkg for the command and link types.
module wtk_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wtk_pkg::cell_cmd_t              cmd_i,
  input  logic [wtk_pkg::KeyWidth-1:0]    new_key_i,
  input  logic [wtk_pkg::CountWidth-1:0]  new_cnt_i,
  input  wtk_pkg::cell_link_t             lo_i,
  input  wtk_pkg::cell_link_t             hi_i,
  output wtk_pkg::cell_link_t             link_o
);

  logic                           valid_q, valid_d;
  logic [wtk_pkg::KeyWidth-1:0]   key_q, key_d;
  logic [wtk_pkg::CountWidth-1:0] cnt_q, cnt_d;
  logic                           le;

  assign le = valid_q && (cnt_q <= new_cnt_i);

  // Next entry: hold, load the new record, or take a neighbor
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    if (cmd_i.shift) begin
      valid_d = hi_i.valid;
      key_d   = hi_i.key;
      cnt_d   = hi_i.cnt;
    end else if (cmd_i.ins) begin
      valid_d = valid_q | lo_i.valid;
      if (!le) begin
        if (lo_i.le) begin
          key_d = new_key_i;
          cnt_d = new_cnt_i;
        end else begin
          key_d = lo_i.key;
          cnt_d = lo_i.cnt;
        end
      end
    end else if (cmd_i.evict) begin
      // store is full here, so valid stays set
      if (hi_i.le) begin
        key_d = hi_i.key;
        cnt_d = hi_i.cnt;
      end else if (le) begin
        key_d = new_key_i;
        cnt_d = new_cnt_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.le    = le;
  assign link_o.key   = key_q;
  assign link_o.cnt   = cnt_q;

endmodule

FILE: design/windowed_top_k_select.sv
`timescale 1ns / 1ps
// Windowed top-K selector: one item accepted per cycle in both modes unless the input
// is stalled; the chain of TOP_K cells inserts a record in the cycle it is accepted.
// A window-last item in top-K mode starts a flush that emits one held entry per cycle
// while the output is not stalled (input stalled meanwhile). Pass-through results
// appear in the cycle after acceptance. Reset (async, active low) empties the store
// and sets select_top to 1. Depends on wtk_pkg and wtk_cell.
module windowed_top_k_select #(
  parameter int unsigned TOP_K = wtk_pkg::TopKDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // record input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [wtk_pkg::IpWidth-1:0]     src_ip_i,
  input  logic [wtk_pkg::IpWidth-1:0]     dst_ip_i,
  input  logic [wtk_pkg::CountWidth-1:0]  count_i,
  input  logic [wtk_pkg::WindowWidth-1:0] window_id_i,
  input  logic                            window_last_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [wtk_pkg::IpWidth-1:0]     out_src_ip_o,
  output logic [wtk_pkg::IpWidth-1:0]     out_dst_ip_o,
  output logic [wtk_pkg::CountWidth-1:0]  out_count_o,
  output logic [wtk_pkg::WindowWidth-1:0] out_window_o,
  output logic                            out_last_o,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_select_top_i
);

  wtk_pkg::cell_link_t links [TOP_K+1];
  wtk_pkg::cell_link_t lo_links [TOP_K];
  wtk_pkg::cell_cmd_t  cmd;

  logic                              sel_q;
  logic                              flush_q, flush_d;
  logic [wtk_pkg::WindowWidth-1:0]   win_q;
  logic                              acc, pass, emit, out_free, full, beats_low;
  logic [wtk_pkg::KeyWidth-1:0]      new_key;

  logic                              out_valid_q, out_valid_d;
  logic [wtk_pkg::IpWidth-1:0]       out_src_q, out_dst_q;
  logic [wtk_pkg::CountWidth-1:0]    out_cnt_q;
  logic [wtk_pkg::WindowWidth-1:0]   out_win_q;
  logic                              out_last_q;

  // Handshakes
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = flush_q || (!sel_q && !out_free);
  assign acc        = in_valid_i && !in_stall_o;
  assign pass       = acc && !sel_q;
  assign emit       = flush_q && out_free;
  assign cfg_ready_o = !flush_q;

  // Chain commands
  assign new_key   = {src_ip_i, dst_ip_i};
  assign full      = links[TOP_K-1].valid;
  assign beats_low = links[0].cnt < count_i;
  assign cmd.ins   = acc && sel_q && !full;
  assign cmd.evict = acc && sel_q && full && beats_low;
  assign cmd.shift = emit;

  // Boundaries: below cell 0 acts as a valid entry <= everything, above the top is empty
  assign links[TOP_K] = '0;

  for (genvar g = 0; g < TOP_K; g++) begin : g_cell
    if (g == 0) begin : g_bottom
      assign lo_links[g] = '{valid: 1'b1, le: 1'b1, key: '0, cnt: '0};
    end else begin : g_inner
      assign lo_links[g] = links[g-1];
    end
    wtk_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .new_key_i (new_key),
      .new_cnt_i (count_i),
      .lo_i      (lo_links[g]),
      .hi_i      (links[g+1]),
      .link_o    (links[g])
    );
  end

  // Flush control
  always_comb begin
    flush_d = flush_q;
    if (acc && sel_q && window_last_i) begin
      flush_d = 1'b1;
    end else if (emit && !links[1].valid) begin
      flush_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b1;
      flush_q <= 1'b0;
    end else begin
      flush_q <= flush_d;
      if (cfg_valid_i && cfg_ready_o) begin
        sel_q <= cfg_select_top_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && window_last_i) begin
      win_q <= window_id_i;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (pass || emit) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pass) begin
      out_src_q  <= src_ip_i;
      out_dst_q  <= dst_ip_i;
      out_cnt_q  <= count_i;
      out_win_q  <= window_id_i;
      out_last_q <= window_last_i;
    end else if (emit) begin
      out_src_q  <= links[0].key[wtk_pkg::KeyWidth-1:wtk_pkg::IpWidth];
      out_dst_q  <= links[0].key[wtk_pkg::IpWidth-1:0];
      out_cnt_q  <= links[0].cnt;
      out_win_q  <= win_q;
      out_last_q <= !links[1].valid;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_src_ip_o = out_src_q;
  assign out_dst_ip_o = out_dst_q;
  assign out_count_o  = out_cnt_q;
  assign out_window_o = out_win_q;
  assign out_last_o   = out_last_q;

  // Checks
  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> links[0].valid)
    else $error("flush with empty store");

  a_last_starts_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && sel_q && window_last_i) |=> flush_q)
    else $error("window-last item did not start a flush");

  a_final_ends_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !links[1].valid) |=> (!flush_q && !links[0].valid))
    else $error("store not emptied after final emit");

  a_no_accept_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !acc)
    else $error("item accepted during flush");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for windowed_top_k_select: a directed table, then random windows,
// scored against a behavioral top-K store kept in the bench or hand-written table results.
// Depends on wtk_pkg and the windowed_top_k_select RTL.
module testbench;

  localparam int unsigned TopK          = wtk_pkg::TopKDefault;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = TopK + 4;
  localparam int unsigned NumDirected   = 23;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseItems    = 19;

  // One record in or one emitted entry out, both have the same shape
  typedef struct packed {
    logic [wtk_pkg::IpWidth-1:0]     src;
    logic [wtk_pkg::IpWidth-1:0]     dst;
    logic [wtk_pkg::CountWidth-1:0]  cnt;
    logic [wtk_pkg::WindowWidth-1:0] win;
    logic                            last;
  } flow_t;

  // Directed row: mode, record, and a hand-written result where one is obvious
  typedef struct packed {
    logic  sel;
    flow_t rec;
    logic  typed;
    flow_t want;
  } dir_row_t;

  logic                            clk_i            = 1'b0;
  logic                            rst_ni           = 1'b0;
  logic                            in_valid_i       = 1'b0;
  logic                            in_stall_o;
  logic [wtk_pkg::IpWidth-1:0]     src_ip_i         = '0;
  logic [wtk_pkg::IpWidth-1:0]     dst_ip_i         = '0;
  logic [wtk_pkg::CountWidth-1:0]  count_i          = '0;
  logic [wtk_pkg::WindowWidth-1:0] window_id_i      = '0;
  logic                            window_last_i    = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i      = 1'b0;
  logic [wtk_pkg::IpWidth-1:0]     out_src_ip_o;
  logic [wtk_pkg::IpWidth-1:0]     out_dst_ip_o;
  logic [wtk_pkg::CountWidth-1:0]  out_count_o;
  logic [wtk_pkg::WindowWidth-1:0] out_window_o;
  logic                            out_last_o;
  logic                            cfg_valid_i      = 1'b0;
  logic                            cfg_ready_o;
  logic                            cfg_select_top_i = 1'b0;

  // Bench-side model of the store and the mode register
  logic [wtk_pkg::KeyWidth-1:0]   held_key [TopK];
  logic [wtk_pkg::CountWidth-1:0] held_cnt [TopK];
  int unsigned                    held_n   = 0;
  logic                           sel_mode = 1'b1;
  flow_t                          pending_emits [$];

  // Idle and hold-off controls shared with the receiver process
  bit          tx_idle  = 1'b0;
  bit          rx_idle  = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  flow_t       seen;
  flow_t       want;

  dir_row_t directed [NumDirected] = '{
    // extremes on an empty store: the closing record comes straight back
    '{1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1},
      1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}},
    '{1'b1, '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 1'b1},
      1'b1, '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 1'b1}},
    // fill the store with ties
    '{1'b1, '{32'h0A00_0001, 32'hC0A8_0001, 32'd5, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_0002, 32'hC0A8_0002, 32'd3, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_0003, 32'hC0A8_0003, 32'd5, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_0004, 32'hC0A8_0004, 32'd7, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_0005, 32'hC0A8_0005, 32'd3, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_0006, 32'hC0A8_0006, 32'd1, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_0007, 32'hC0A8_0007, 32'd9, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_0008, 32'hC0A8_0008, 32'd5, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_0009, 32'hC0A8_0009, 32'd2, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_000A, 32'hC0A8_000A, 32'd8, 16'h0021, 1'b0}, 1'b0, '0},
    // full store: equal to the lowest and below it are dropped
    '{1'b1, '{32'h0A00_000B, 32'hC0A8_000B, 32'd1, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_000C, 32'hC0A8_000C, 32'd0, 16'h0021, 1'b0}, 1'b0, '0},
    // greater than the lowest evicts it; a foreign window id mixed in
    '{1'b1, '{32'h0A00_000D, 32'hC0A8_000D, 32'd3, 16'h0021, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_000E, 32'hC0A8_000E, 32'hFFFF_FFFF, 16'h0022, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h0A00_000F, 32'hC0A8_000F, 32'd4, 16'h0021, 1'b1}, 1'b0, '0},
    // held entries survive a pass-through stretch
    '{1'b1, '{32'h1111_1111, 32'h2222_2222, 32'd6, 16'h0005, 1'b0}, 1'b0, '0},
    '{1'b1, '{32'h3333_3333, 32'h4444_4444, 32'd6, 16'h0005, 1'b0}, 1'b0, '0},
    '{1'b0, '{32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 16'h8000, 1'b0},
      1'b1, '{32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 16'h8000, 1'b0}},
    '{1'b0, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 16'h7FFF, 1'b1},
      1'b1, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 16'h7FFF, 1'b1}},
    '{1'b1, '{32'h6666_6666, 32'h7777_7777, 32'd6, 16'h0007, 1'b1}, 1'b0, '0},
    // store empty again: a lone closing record is its own result
    '{1'b1, '{32'h0000_0000, 32'h0000_0000, 32'd0, 16'h0000, 1'b1},
      1'b1, '{32'h0000_0000, 32'h0000_0000, 32'd0, 16'h0000, 1'b1}}
  };

  windowed_top_k_select #(
    .TOP_K(TopK)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .src_ip_i        (src_ip_i),
    .dst_ip_i        (dst_ip_i),
    .count_i         (count_i),
    .window_id_i     (window_id_i),
    .window_last_i   (window_last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_src_ip_o    (out_src_ip_o),
    .out_dst_ip_o    (out_dst_ip_o),
    .out_count_o     (out_count_o),
    .out_window_o    (out_window_o),
    .out_last_o      (out_last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_select_top_i(cfg_select_top_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Counts mostly small so ties and drops are common, plus full-range and near-max values
  function automatic logic [wtk_pkg::CountWidth-1:0] rand_count();
    case ($urandom_range(0, 3))
      0:       rand_count = $urandom_range(0, 7);
      1:       rand_count = $urandom;
      2:       rand_count = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: rand_count = $urandom_range(0, 1000);
    endcase
  endfunction

  // Append one expected result at the tail of the queue
  task automatic queue_result(input flow_t e);
    pending_emits = {pending_emits, e};
  endtask

  // Update the bench store with one accepted record; queue what it emits when asked to
  task automatic rank_record(input flow_t r, input bit record);
    int unsigned pos;
    int unsigned i;
    flow_t       res;
    if (!sel_mode) begin
      if (record) queue_result(r);
      return;
    end
    if (held_n < TopK || r.cnt > held_cnt[0]) begin
      // full store: the lowest (earliest among ties) goes first
      if (held_n == TopK) begin
        for (i = 1; i < held_n; i++) begin
          held_key[i-1] = held_key[i];
          held_cnt[i-1] = held_cnt[i];
        end
        held_n--;
      end
      // insert after every entry with count <= new count
      pos = 0;
      while (pos < held_n && held_cnt[pos] <= r.cnt) pos++;
      for (i = held_n; i > pos; i--) begin
        held_key[i] = held_key[i-1];
        held_cnt[i] = held_cnt[i-1];
      end
      held_key[pos] = {r.src, r.dst};
      held_cnt[pos] = r.cnt;
      held_n++;
    end
    if (r.last) begin
      for (i = 0; i < held_n; i++) begin
        res.src  = held_key[i][wtk_pkg::KeyWidth-1:wtk_pkg::IpWidth];
        res.dst  = held_key[i][wtk_pkg::IpWidth-1:0];
        res.cnt  = held_cnt[i];
        res.win  = r.win;
        res.last = (i + 1 == held_n);
        if (record) queue_result(res);
      end
      held_n = 0;
    end
  endtask

  // Offer one record, with an optional idle burst ahead of it; returns at the accepting edge
  task automatic send_record(input flow_t r, input bit typed, input flow_t hand_want);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    src_ip_i      <= r.src;
    dst_ip_i      <= r.dst;
    count_i       <= r.cnt;
    window_id_i   <= r.win;
    window_last_i <= r.last;
    do @(posedge clk_i); while (in_stall_o);
    rank_record(r, !typed);
    if (typed) queue_result(hand_want);
  endtask

  // Mode write, only once the block has drained
  task automatic write_select(input logic v);
    in_valid_i <= 1'b0;
    while (pending_emits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_select_top_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sel_mode = v;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Scoreboard: each accepted result against the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{out_src_ip_o, out_dst_ip_o, out_count_o, out_window_o, out_last_o};
      if (pending_emits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: src %h dst %h cnt %h win %h last %b",
                   seen.src, seen.dst, seen.cnt, seen.win, seen.last);
      end else begin
        want = pending_emits.pop_front();
        if (seen.src !== want.src || seen.dst !== want.dst || seen.cnt !== want.cnt ||
            seen.win !== want.win || seen.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: src %h dst %h cnt %h win %h last %b",
                     want.src, want.dst, want.cnt, want.win, want.last);
            $display("         got: src %h dst %h cnt %h win %h last %b",
                     seen.src, seen.dst, seen.cnt, seen.win, seen.last);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int unsigned                     k;
    int unsigned                     phase;
    int unsigned                     n;
    int unsigned                     len;
    int unsigned                     j;
    logic                            sel;
    logic [wtk_pkg::WindowWidth-1:0] win;
    flow_t                           r;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed table
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (k = 0; k < NumDirected; k++) begin
      if (directed[k].sel != sel_mode) write_select(directed[k].sel);
      send_record(directed[k].rec, directed[k].typed, directed[k].want);
    end

    // random phases; a window cut by a phase end carries its entries into the next
    for (phase = 0; phase < NumPhases; phase++) begin
      sel = ((phase % 3) != 2);
      write_select(sel);
      tx_idle = (phase != 3) && (phase != NumPhases - 1);
      rx_idle = tx_idle;
      if (phase == 2) hold_req = 1'b1;
      n = 0;
      while (n < PhaseItems) begin
        len = sel ? $urandom_range(1, 24) : 1;
        win = wtk_pkg::WindowWidth'($urandom_range(0, 65535));
        for (j = 0; j < len; j++) begin
          if (n >= PhaseItems && phase != NumPhases - 1) break;
          r.src = $urandom;
          r.dst = $urandom;
          r.cnt = rand_count();
          // occasional stray window id inside a window
          r.win = ($urandom_range(0, 9) == 0) ? wtk_pkg::WindowWidth'($urandom) : win;
          if (sel)
            r.last = (j == len - 1) || ($urandom_range(0, 14) == 0);
          else
            r.last = 1'($urandom_range(0, 1));
          send_record(r, 1'b0, '0);
          n++;
          if (sel && r.last) break;
        end
      end
    end

    // drain and report
    in_valid_i <= 1'b0;
    while (pending_emits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_emits.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
